@@ sv/assert_macros.svh @@
// assertion macros for the rotation matrix to euler checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is low
`define RM2EUL_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// clocked assertion that also checks around reset
`define RM2EUL_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/rm2eul_pkg.sv @@
// shared types and constants for the rotation matrix to euler unit
// no dependencies
`default_nettype none

package rm2eul_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int CORDIC_STEPS   = 16;
    localparam int THR_W          = 11;
    localparam int ANGLE_W        = 16;
    localparam int SQ_W           = 2 * SAMPLE_WIDTH;
    localparam int RT_W           = SAMPLE_WIDTH;
    localparam int OP_W           = SAMPLE_WIDTH + 2;
    localparam int PRESCALE_SHIFT = 14;
    localparam int XY_W           = OP_W + PRESCALE_SHIFT + 2;
    localparam int ANGLE_SHIFT    = 17;
    localparam int ATAN_LEN       = 31;

    localparam logic [THR_W-1:0]          THR_RESET  = THR_W'(1);
    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX  = ANGLE_W'(25736);
    localparam logic signed [XY_W-1:0]    HALF_PI_Z  = XY_W'(1686629713);
    localparam logic signed [XY_W-1:0]    ROUND_BIAS = XY_W'(65536);

    // floor(atan(2^-i) * 2^30)
    localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133524134, 32'd67021686,
        32'd33543515,  32'd16775850,  32'd8388437,   32'd4194282,   32'd2097149,
        32'd1048575,   32'd524287,    32'd262143,    32'd131071,    32'd65535,
        32'd32767,     32'd16383,     32'd8191,      32'd4095,      32'd2047,
        32'd1023,      32'd511,       32'd255,       32'd127,       32'd63,
        32'd31,        32'd15,        32'd7,         32'd3,         32'd1,
        32'd0
    };

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] r00;
        logic signed [SAMPLE_WIDTH-1:0] r10;
        logic signed [SAMPLE_WIDTH-1:0] r20;
        logic signed [SAMPLE_WIDTH-1:0] r21;
        logic signed [SAMPLE_WIDTH-1:0] r22;
        logic signed [SAMPLE_WIDTH-1:0] r11;
        logic signed [SAMPLE_WIDTH-1:0] r12;
    } s_payload_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] yaw;
        logic                      singular;
    } m_payload_t;

endpackage

`default_nettype wire

@@ sv/rotation_matrix_to_euler_unit.sv @@
// rotation matrix to z-y-x euler angles as a fixed-point pipeline; uses rm2eul_pkg
// throughput: one transaction per cycle unless stalled; each sqrt digit and each cordic
// iteration has its own stage, and the pipe only stalls when the output register holds a
// result that is not taken and the last stage is full
// reset: synchronous active-low aresetn clears all valid bits, loads threshold 1
`default_nettype none

module rotation_matrix_to_euler_unit (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  rm2eul_pkg::s_payload_t   s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output rm2eul_pkg::m_payload_t   m_data,
    input  logic                     cfg_wr_en,
    input  logic [rm2eul_pkg::THR_W-1:0] cfg_wr_data
);

    import rm2eul_pkg::*;

    // square root working pair: remainder and partial root
    typedef struct packed {
        logic [SQ_W-1:0] n;
        logic [SQ_W-1:0] r;
    } sq_t;

    // one cordic vectoring lane; zero marks atan2(0, 0)
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [XY_W-1:0] z;
        logic                   zero;
    } lane_t;

    // three lanes travel side by side with the gimbal lock flag
    typedef struct packed {
        lane_t roll;
        lane_t pitch;
        lane_t yaw;
        logic  sing;
    } cord_t;

    // one digit of the restoring integer square root
    function automatic sq_t sqrt_step(input sq_t s, input int k);
        logic [SQ_W-1:0] sq_bit;
        logic [SQ_W:0]   trial;
        sq_t             o;
        sq_bit = SQ_W'(1) << (SQ_W - 2 - 2 * k);
        trial  = {1'b0, s.r} + {1'b0, sq_bit};
        if ({1'b0, s.n} >= trial) begin
            o.n = s.n - trial[SQ_W-1:0];
            o.r = (s.r >> 1) + sq_bit;
        end else begin
            o.n = s.n;
            o.r = s.r >> 1;
        end
        return o;
    endfunction

    // quadrant fold into the right half plane, then scale up
    function automatic lane_t lane_init(input logic signed [OP_W-1:0] y_in,
                                        input logic signed [OP_W-1:0] x_in);
        logic signed [XY_W-1:0] xe;
        logic signed [XY_W-1:0] ye;
        lane_t                  l;
        xe     = XY_W'(x_in);
        ye     = XY_W'(y_in);
        l.zero = (x_in == '0) && (y_in == '0);
        if (xe[XY_W-1]) begin
            if (!ye[XY_W-1]) begin
                l.x = ye;
                l.y = -xe;
                l.z = HALF_PI_Z;
            end else begin
                l.x = -ye;
                l.y = xe;
                l.z = -HALF_PI_Z;
            end
        end else begin
            l.x = xe;
            l.y = ye;
            l.z = '0;
        end
        l.x = l.x <<< PRESCALE_SHIFT;
        l.y = l.y <<< PRESCALE_SHIFT;
        return l;
    endfunction

    // one micro-rotation, driving y toward zero
    function automatic lane_t lane_step(input lane_t l, input int sh,
                                        input logic signed [XY_W-1:0] t);
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        lane_t                  o;
        xs = l.x >>> sh;
        ys = l.y >>> sh;
        if (!l.y[XY_W-1]) begin
            o.x = l.x + ys;
            o.y = l.y - xs;
            o.z = l.z + t;
        end else begin
            o.x = l.x - ys;
            o.y = l.y + xs;
            o.z = l.z - t;
        end
        o.zero = l.zero;
        return o;
    endfunction

    function automatic cord_t cord_step(input cord_t c, input int sh,
                                        input logic signed [XY_W-1:0] t);
        cord_t o;
        o.roll  = lane_step(c.roll, sh, t);
        o.pitch = lane_step(c.pitch, sh, t);
        o.yaw   = lane_step(c.yaw, sh, t);
        o.sing  = c.sing;
        return o;
    endfunction

    // round half up to q2.13 and clamp to +-pi
    function automatic logic signed [ANGLE_W-1:0] angle_out(input lane_t l);
        logic signed [XY_W-1:0]    zr;
        logic signed [ANGLE_W-1:0] a;
        zr = (l.z + ROUND_BIAS) >>> ANGLE_SHIFT;
        if (l.zero) begin
            a = '0;
        end else if (zr > XY_W'(ANGLE_MAX)) begin
            a = ANGLE_MAX;
        end else if (zr < -XY_W'(ANGLE_MAX)) begin
            a = -ANGLE_MAX;
        end else begin
            a = ANGLE_W'(zr);
        end
        return a;
    endfunction

    // configuration
    logic [THR_W-1:0] thr_reg;

    // global advance: stall only when the output is held and the last stage is full
    logic pipe_en;

    // square stage
    logic                    v1_reg;
    s_payload_t              p1_reg;
    logic [SAMPLE_WIDTH-1:0] abs_a;
    logic [SAMPLE_WIDTH-1:0] abs_b;
    logic [SQ_W-1:0]         sqa_reg;
    logic [SQ_W-1:0]         sqb_reg;
    logic [SQ_W-1:0]         sqa_next;
    logic [SQ_W-1:0]         sqb_next;

    // square root stages, element 0 holds the sum of squares
    logic [RT_W:0]           qv_reg;
    s_payload_t [RT_W:0]     qp_reg;
    sq_t [RT_W:0]            sq_reg;
    sq_t                     sq0_next;
    sq_t [RT_W-1:0]          sq_next;

    // branch select stage
    logic [RT_W-1:0]         sy;
    logic                    sing;
    logic signed [OP_W-1:0]  roll_y;
    logic signed [OP_W-1:0]  roll_x;
    cord_t                   cs0_next;

    // cordic stages, element 0 holds the folded operands
    logic [CORDIC_STEPS:0]   cv_reg;
    cord_t [CORDIC_STEPS:0]  cs_reg;
    cord_t [CORDIC_STEPS-1:0] cs_next;

    // output register
    logic                    m_valid_reg;
    m_payload_t              m_data_reg;
    m_payload_t              m_data_next;

    assign pipe_en = !(m_valid_reg && !m_ready && cv_reg[CORDIC_STEPS]);
    assign s_ready = pipe_en;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    // magnitudes of r00 and r10, one multiplier each
    assign abs_a    = s_data.r00[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-s_data.r00) : s_data.r00;
    assign abs_b    = s_data.r10[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-s_data.r10) : s_data.r10;
    assign sqa_next = abs_a * abs_a;
    assign sqb_next = abs_b * abs_b;

    assign sq0_next.n = sqa_reg + sqb_reg;
    assign sq0_next.r = '0;

    generate
        for (genvar g = 0; g < RT_W; g++) begin : g_sqrt
            assign sq_next[g] = sqrt_step(sq_reg[g], g);
        end
    endgenerate

    // singular decision and operand choice once sy is known
    always_comb begin
        sy   = sq_reg[RT_W].r[RT_W-1:0];
        sing = sy < RT_W'(thr_reg);
        if (sing) begin
            roll_y = -OP_W'(qp_reg[RT_W].r12);
            roll_x = OP_W'(qp_reg[RT_W].r11);
        end else begin
            roll_y = OP_W'(qp_reg[RT_W].r21);
            roll_x = OP_W'(qp_reg[RT_W].r22);
        end
        cs0_next.roll  = lane_init(roll_y, roll_x);
        cs0_next.pitch = lane_init(-OP_W'(qp_reg[RT_W].r20), $signed(OP_W'(sy)));
        cs0_next.yaw   = lane_init(OP_W'(qp_reg[RT_W].r10), OP_W'(qp_reg[RT_W].r00));
        cs0_next.sing  = sing;
    end

    generate
        for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
            assign cs_next[g] = cord_step(cs_reg[g], g, $signed(XY_W'(ATAN_TAB[g])));
        end
    endgenerate

    // final rounding; yaw is forced to zero in gimbal lock
    always_comb begin
        m_data_next.roll     = angle_out(cs_reg[CORDIC_STEPS].roll);
        m_data_next.pitch    = angle_out(cs_reg[CORDIC_STEPS].pitch);
        m_data_next.yaw      = cs_reg[CORDIC_STEPS].sing ? '0
                                                         : angle_out(cs_reg[CORDIC_STEPS].yaw);
        m_data_next.singular = cs_reg[CORDIC_STEPS].sing;
    end

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            qv_reg <= '0;
            cv_reg <= '0;
        end else if (pipe_en) begin
            v1_reg <= s_valid;
            qv_reg <= {qv_reg[RT_W-1:0], v1_reg};
            cv_reg <= {cv_reg[CORDIC_STEPS-1:0], qv_reg[RT_W]};
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            p1_reg  <= s_data;
            sqa_reg <= sqa_next;
            sqb_reg <= sqb_next;
            qp_reg  <= {qp_reg[RT_W-1:0], p1_reg};
            sq_reg  <= {sq_next, sq0_next};
            cs_reg  <= {cs_next, cs0_next};
        end
    end

    // output register: loads when the last stage advances, clears on transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_en && cv_reg[CORDIC_STEPS]) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en && cv_reg[CORDIC_STEPS]) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/rm2eul_checker.sv @@
// port-level checks for rotation_matrix_to_euler_unit, attached by bind
// depends on rm2eul_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rm2eul_checker (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input rm2eul_pkg::m_payload_t m_data
);

    import rm2eul_pkg::*;

    function automatic logic in_pi(input logic signed [ANGLE_W-1:0] a);
        return (a <= ANGLE_MAX) && (a >= -ANGLE_MAX);
    endfunction

    logic held;
    logic yaw_ok;
    logic angles_ok;
    logic idle_out;

    assign held      = m_valid && !m_ready;
    assign yaw_ok    = !m_data.singular || (m_data.yaw == '0);
    assign angles_ok = in_pi(m_data.roll) && in_pi(m_data.pitch) && in_pi(m_data.yaw);
    assign idle_out  = !m_valid && s_ready;

    // a held result stays put until its transaction
    `RM2EUL_ASSERT(a_valid_hold, aclk, aresetn, held |=> m_valid, "result dropped in stall")
    `RM2EUL_ASSERT(a_out_hold, aclk, aresetn, held |=> $stable(m_data), "result changed in stall")

    // gimbal lock always reports zero yaw
    `RM2EUL_ASSERT(a_yaw_zero, aclk, aresetn, m_valid |-> yaw_ok, "nonzero yaw in gimbal lock")

    // angles never leave +-pi
    `RM2EUL_ASSERT(a_angle_range, aclk, aresetn, m_valid |-> angles_ok, "angle out of range")

    // right after reset the pipe is empty and open
    `RM2EUL_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> idle_out, "pipe not empty after reset")

endmodule

bind rotation_matrix_to_euler_unit rm2eul_checker u_rm2eul_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

@@ tb/rotation_matrix_to_euler_unit_tb.sv @@
// self-checking testbench for rotation_matrix_to_euler_unit: directed and random matrices
// are checked against an in-bench cordic model of roll, pitch, yaw and the gimbal flag
// depends on rm2eul_pkg and the unit's rtl
module rotation_matrix_to_euler_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rm2eul_pkg::*;

    localparam int     CLK_HALF     = 5;
    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     PIPE_DRAIN   = 40;
    localparam int     RAND_PER_SET = 140;     // random matrices per threshold setting
    localparam int     MAX_WAIT     = 12;
    localparam int     ITERATIONS   = 16;
    localparam longint Q14_ONE      = 16384;
    localparam longint HALF_PI_Q30  = 1686629713;
    localparam longint PI_Q13       = 25736;

    // arctangent of 2^-i in units of 2^-30 rad, truncated
    longint atan_q30 [ITERATIONS] = '{
        843314856, 497837829, 263043836, 133524134, 67021686,
        33543515,  16775850,  8388437,   4194282,   2097149,
        1048575,   524287,    262143,    131071,    65535,
        32767
    };

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    s_payload_t       s_data;
    logic             m_valid;
    logic             m_ready;
    m_payload_t       m_data;
    logic             cfg_wr_en;
    logic [THR_W-1:0] cfg_wr_data;

    int unsigned      cycle_count;
    int unsigned      settings_used;
    logic [THR_W-1:0] thr_plan [5];

    // idle pattern state per side: a stretch either idles at random or runs flat out
    int unsigned      src_run = 0;
    int unsigned      snk_run = 0;
    bit               src_lazy = 0;
    bit               snk_lazy = 0;

    // ---------------------------------------------------------------
    // bit-true model of the datapath
    // ---------------------------------------------------------------

    // floor of the square root, built one result bit at a time
    function automatic longint isqrt_floor(longint n);
        longint root;
        longint trial;
        root = 0;
        for (int k = 16; k >= 0; k--) begin
            trial = root | (longint'(1) << k);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    // vectoring cordic atan2, q1.14 arguments, q2.13 radians out
    function automatic logic signed [ANGLE_W-1:0] cordic_angle(longint yin, longint xin);
        longint x, y, z, t, dx, dy, q;
        if (xin == 0 && yin == 0)
            return '0;
        x = xin * Q14_ONE;
        y = yin * Q14_ONE;
        z = 0;
        // left half plane: quarter turn first so the loop converges
        if (x < 0) begin
            if (y >= 0) begin
                t = y;
                y = -x;
                x = t;
                z = HALF_PI_Q30;
            end else begin
                t = -y;
                y = x;
                x = t;
                z = -HALF_PI_Q30;
            end
        end
        for (int i = 0; i < ITERATIONS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + atan_q30[i];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - atan_q30[i];
            end
        end
        // round half up into q2.13, then clamp to +-pi
        q = (z + 65536) >>> 17;
        if (q > PI_Q13)
            q = PI_Q13;
        if (q < -PI_Q13)
            q = -PI_Q13;
        return ANGLE_W'(q);
    endfunction

    function automatic m_payload_t euler_from_matrix(s_payload_t m, logic [THR_W-1:0] thr);
        longint a, b, sy;
        m_payload_t e;
        a = longint'($signed(m.r00));
        b = longint'($signed(m.r10));
        sy = isqrt_floor(a * a + b * b);
        e.singular = (sy < longint'(thr));
        e.pitch = cordic_angle(-longint'($signed(m.r20)), sy);
        if (e.singular) begin
            // gimbal lock: roll from the second row, yaw forced to zero
            e.roll = cordic_angle(-longint'($signed(m.r12)), longint'($signed(m.r11)));
            e.yaw  = '0;
        end else begin
            e.roll = cordic_angle(longint'($signed(m.r21)), longint'($signed(m.r22)));
            e.yaw  = cordic_angle(b, a);
        end
        return e;
    endfunction

    // ---------------------------------------------------------------
    // scoreboard: one expected angle set per accepted matrix, in order
    // ---------------------------------------------------------------
    class euler_scoreboard;
        logic [THR_W-1:0] threshold = THR_RESET;
        m_payload_t       pending_angles [$];
        int unsigned      checked = 0;
        int unsigned      gimbal_hits = 0;
        int unsigned      errors = 0;

        function void note_matrix(s_payload_t m);
            pending_angles.insert(pending_angles.size(), euler_from_matrix(m, threshold));
        endfunction

        function void check_angles(m_payload_t got);
            m_payload_t want;
            if (pending_angles.size() == 0) begin
                $error("result with no matrix outstanding: roll %0d pitch %0d yaw %0d sing %0b",
                       got.roll, got.pitch, got.yaw, got.singular);
                errors++;
                return;
            end
            want = pending_angles.pop_front();
            checked++;
            if (want.singular)
                gimbal_hits++;
            if (got.roll !== want.roll) begin
                $error("roll mismatch on result %0d: expected %0d, actual %0d",
                       checked, want.roll, got.roll);
                errors++;
            end
            if (got.pitch !== want.pitch) begin
                $error("pitch mismatch on result %0d: expected %0d, actual %0d",
                       checked, want.pitch, got.pitch);
                errors++;
            end
            if (got.yaw !== want.yaw) begin
                $error("yaw mismatch on result %0d: expected %0d, actual %0d",
                       checked, want.yaw, got.yaw);
                errors++;
            end
            if (got.singular !== want.singular) begin
                $error("singular mismatch on result %0d: expected %0b, actual %0b",
                       checked, want.singular, got.singular);
                errors++;
            end
        endfunction
    endclass

    euler_scoreboard sb;

    // ---------------------------------------------------------------
    // dut
    // ---------------------------------------------------------------
    rotation_matrix_to_euler_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // monitor: every transaction is seen at the rising edge, inputs settled since the falling one
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_matrix(s_data);
            if (m_valid && m_ready)
                sb.check_angles(m_data);
        end
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still outstanding",
                 cycle_count, sb.pending_angles.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // wait length for the next transaction on one side
    function automatic int unsigned draw_wait(ref int unsigned run_left, ref bit lazy);
        if (run_left == 0) begin
            run_left = $urandom_range(8, 60);
            lazy = ($urandom_range(0, 2) != 0);
        end
        run_left--;
        return lazy ? $urandom_range(0, MAX_WAIT) : 0;
    endfunction

    function automatic s_payload_t matrix_of(int r00, int r10, int r20, int r21, int r22,
                                             int r11, int r12);
        s_payload_t m;
        m.r00 = 16'(r00);
        m.r10 = 16'(r10);
        m.r20 = 16'(r20);
        m.r21 = 16'(r21);
        m.r22 = 16'(r22);
        m.r11 = 16'(r11);
        m.r12 = 16'(r12);
        return m;
    endfunction

    function automatic logic signed [15:0] q14_any();
        return 16'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic logic signed [15:0] q14_of(real v);
        return 16'($rtoi(v * 16384.0 + ((v < 0.0) ? -0.5 : 0.5)));
    endfunction

    function automatic real rand_angle();
        return (real'($urandom_range(0, 20000)) / 20000.0 - 0.5) * 6.2831853;
    endfunction

    // mix of plain random, near-gimbal, raw 16-bit and true rotation matrices
    function automatic s_payload_t random_matrix(logic [THR_W-1:0] thr);
        s_payload_t m;
        int unsigned kind;
        int lim;
        real ra, pa, ya;
        kind = $urandom_range(0, 9);
        if (kind == 6) begin
            // any bit pattern, often well outside q1.14
            m.r00 = 16'($urandom());
            m.r10 = 16'($urandom());
            m.r20 = 16'($urandom());
            m.r21 = 16'($urandom());
            m.r22 = 16'($urandom());
            m.r11 = 16'($urandom());
            m.r12 = 16'($urandom());
        end else if (kind >= 7) begin
            ra = rand_angle();
            ya = rand_angle();
            pa = rand_angle() / 2.0;
            // sometimes pitch right at the pole so sy lands near the threshold
            if ($urandom_range(0, 3) == 0)
                pa = ($urandom_range(0, 1) ? 1.5707963 : -1.5707963)
                     + (real'($urandom_range(0, 200)) - 100.0) * 1.0e-5;
            m.r00 = q14_of($cos(ya) * $cos(pa));
            m.r10 = q14_of($sin(ya) * $cos(pa));
            m.r20 = q14_of(-$sin(pa));
            m.r21 = q14_of($cos(pa) * $sin(ra));
            m.r22 = q14_of($cos(pa) * $cos(ra));
            m.r11 = q14_of($sin(ya) * $sin(pa) * $sin(ra) + $cos(ya) * $cos(ra));
            m.r12 = q14_of($sin(ya) * $sin(pa) * $cos(ra) - $cos(ya) * $sin(ra));
        end else begin
            m.r00 = q14_any();
            m.r10 = q14_any();
            m.r20 = q14_any();
            m.r21 = q14_any();
            m.r22 = q14_any();
            m.r11 = q14_any();
            m.r12 = q14_any();
            if (kind >= 4) begin
                // first column straddling the threshold
                lim = int'(thr) + 48;
                m.r00 = 16'(int'($urandom_range(0, 2 * lim)) - lim);
                m.r10 = 16'(int'($urandom_range(0, 2 * lim)) - lim);
                if ($urandom_range(0, 1))
                    m.r20 = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
            end
        end
        return m;
    endfunction

    // one input transaction: optional gap, then hold valid until taken
    task automatic send_matrix(s_payload_t m);
        int unsigned gap;
        gap = draw_wait(src_run, src_lazy);
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= m;
        do @(posedge aclk); while (!s_ready);
    endtask

    // result side: random stalls before each transaction, then wait for it
    task automatic run_result_sink();
        int unsigned stall;
        forever begin
            stall = draw_wait(snk_run, snk_lazy);
            repeat (stall) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    endtask

    // stop sending and wait for every expected result
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending_angles.size() != 0)
            @(posedge aclk);
    endtask

    // threshold change only with the pipe empty
    task automatic write_threshold(logic [THR_W-1:0] thr);
        drain_results();
        repeat (8) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= thr;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.threshold = thr;
        settings_used++;
    endtask

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial begin
        sb = new();
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        settings_used = 1;
        thr_plan = '{11'd0, 11'd1024, 11'd2047, 11'd0, 11'd1};
        thr_plan[3] = THR_W'($urandom_range(2, 1023));

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        fork
            run_result_sink();
        join_none

        // directed matrices under the reset threshold of one
        send_matrix(matrix_of(0, 0, 0, 0, 0, 0, 0));                 // every atan2 of (0, 0)
        send_matrix(matrix_of(16384, 0, 0, 0, 16384, 16384, 0));     // identity
        send_matrix(matrix_of(16384, 16384, 16384, 16384, 16384, 16384, 16384));
        send_matrix(matrix_of(-16384, -16384, -16384, -16384, -16384, -16384, -16384));
        send_matrix(matrix_of(32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_matrix(matrix_of(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_matrix(matrix_of(21845, 21845, 21845, 21845, 21845, 21845, 21845));
        send_matrix(matrix_of(-21846, -21846, -21846, -21846, -21846, -21846, -21846));
        // zero y with negative x gives +pi for roll and yaw
        send_matrix(matrix_of(-16384, 0, 0, 0, -16384, 16384, 0));
        send_matrix(matrix_of(-32768, 0, 0, 0, -32768, 0, 0));
        // left half plane with y just below zero
        send_matrix(matrix_of(-16384, -1, 100, -16384, -1, 16384, 0));
        // gimbal lock, pitch at both poles, roll in different quadrants
        send_matrix(matrix_of(0, 0, -16384, 0, 0, 16384, -16384));
        send_matrix(matrix_of(0, 0, 16384, 0, 0, -16384, 16384));
        send_matrix(matrix_of(0, 0, 16384, 5, 5, -16384, 0));
        // sy of exactly one sits on the threshold and stays regular
        send_matrix(matrix_of(1, 0, -32768, 7, -7, 100, 100));
        send_matrix(matrix_of(0, -1, 32767, -3, 0, 0, 0));
        // tiny angles everywhere
        send_matrix(matrix_of(16384, 1, -1, 1, 16384, 16384, 0));
        send_matrix(matrix_of(16384, -1, 1, -1, 16384, 16384, -1));

        repeat (RAND_PER_SET)
            send_matrix(random_matrix(sb.threshold));

        // threshold sweep: zero, the nominal top, the 11-bit top, a random one, back to one
        foreach (thr_plan[i]) begin
            write_threshold(thr_plan[i]);
            // sy equal to the threshold, one below it (one above for a zero threshold), and all zero
            send_matrix(matrix_of(int'(thr_plan[i]), 0, 300, -200, 50, 40, -30));
            send_matrix(matrix_of(0, 1 - int'(thr_plan[i]), -300, 200, -50, -40, 30));
            send_matrix(matrix_of(0, 0, 0, 0, 0, 0, 0));
            repeat (RAND_PER_SET)
                send_matrix(random_matrix(sb.threshold));
        end

        drain_results();
        repeat (PIPE_DRAIN) @(posedge aclk);

        $display("covered %0d matrices, %0d through the gimbal lock branch, %0d threshold settings",
                 sb.checked, sb.gimbal_hits, settings_used);
        $display("field mismatches and stray results: %0d", sb.errors);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
